### hw/rtl/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ROOT_WIDTH     = 41;
   localparam int RSP_TDATA_W    = 88;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   localparam logic STAT_OK      = 1'b0;
   localparam logic STAT_NOT_QUAD = 1'b1;

   // Control that rides along with every equation through the pipeline.
   typedef struct packed {
      logic       valid;
      logic [1:0] root_count;
      logic       status;
   } ctl_type;

endpackage

### hw/rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One restoring square root cell: settles one root bit per cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
   parameter int RB = 33,
   parameter int SW = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  qrs_pkg::ctl_type     ctl_in,
   input  logic [2*RB-1:0]      x_in,
   input  logic [RB+1:0]        rem_in,
   input  logic [RB-1:0]        q_in,
   input  logic [SW-1:0]        side_in,
   output qrs_pkg::ctl_type     ctl_out,
   output logic [2*RB-1:0]      x_out,
   output logic [RB+1:0]        rem_out,
   output logic [RB-1:0]        q_out,
   output logic [SW-1:0]        side_out
);
   import qrs_pkg::*;

   ctl_type          ctl_ff;
   logic [2*RB-1:0]  x_ff;
   logic [RB+1:0]    rem_ff;
   logic [RB-1:0]    q_ff;
   logic [SW-1:0]    side_ff;
   logic [RB+3:0]    acc;
   logic [RB+3:0]    trial;
   logic [RB+3:0]    diff;
   logic             take;

   // Bring down the next two radicand bits and try root bit one.
   always_comb begin
      acc   = {rem_in, x_in[2*RB-1 -: 2]};
      trial = {2'b00, q_in, 2'b01};
      take  = (acc >= trial);
      diff  = acc - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= {x_in[2*RB-3:0], 2'b00};
         rem_ff  <= take ? diff[RB+1:0] : acc[RB+1:0];
         q_ff    <= {q_in[RB-2:0], take};
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign x_out    = x_ff;
   assign rem_out  = rem_ff;
   assign q_out    = q_ff;
   assign side_out = side_ff;

endmodule

### hw/rtl/qrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring divider cell for both root lanes: one quotient bit per cell.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
   parameter int N   = 34,
   parameter int DVW = 17,
   parameter int SW  = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  qrs_pkg::ctl_type     ctl_in,
   input  logic [DVW-1:0]       den_in,
   input  logic [N-1:0]         np_in,
   input  logic [N-1:0]         nm_in,
   input  logic [DVW-1:0]       remp_in,
   input  logic [DVW-1:0]       remm_in,
   input  logic [SW-1:0]        side_in,
   output qrs_pkg::ctl_type     ctl_out,
   output logic [DVW-1:0]       den_out,
   output logic [N-1:0]         np_out,
   output logic [N-1:0]         nm_out,
   output logic [DVW-1:0]       remp_out,
   output logic [DVW-1:0]       remm_out,
   output logic [SW-1:0]        side_out
);
   import qrs_pkg::*;

   ctl_type         ctl_ff;
   logic [DVW-1:0]  den_ff;
   logic [N-1:0]    np_ff;
   logic [N-1:0]    nm_ff;
   logic [DVW-1:0]  remp_ff;
   logic [DVW-1:0]  remm_ff;
   logic [SW-1:0]   side_ff;
   logic [DVW:0]    accp;
   logic [DVW:0]    accm;
   logic [DVW:0]    difp;
   logic [DVW:0]    difm;
   logic            takep;
   logic            takem;

   // The dividend shifts out at the top while quotient bits shift in below.
   always_comb begin
      accp  = {remp_in, np_in[N-1]};
      accm  = {remm_in, nm_in[N-1]};
      takep = (accp >= {1'b0, den_in});
      takem = (accm >= {1'b0, den_in});
      difp  = accp - {1'b0, den_in};
      difm  = accm - {1'b0, den_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= den_in;
         np_ff   <= {np_in[N-2:0], takep};
         nm_ff   <= {nm_in[N-2:0], takem};
         remp_ff <= takep ? difp[DVW-1:0] : accp[DVW-1:0];
         remm_ff <= takem ? difm[DVW-1:0] : accm[DVW-1:0];
         side_ff <= side_in;
      end
   end

   assign ctl_out  = ctl_ff;
   assign den_out  = den_ff;
   assign np_out   = np_ff;
   assign nm_out   = nm_ff;
   assign remp_out = remp_ff;
   assign remm_out = remm_ff;
   assign side_out = side_ff;

endmodule

### hw/rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// The chain is COEF_WIDTH + FRAC_BITS + 1 square root cells plus COEF_WIDTH + FRAC_BITS + 2
// divider cells plus four registers (stages A, B, C and the output register).
// Throughput: one transaction per cycle when not stalled; every cell hands its work to the next.
// The whole chain advances together and holds only while a result waits on rsp_tready.
// Reset (synchronous, active high) clears every valid flag; data registers keep their value.
// While reset is high req_tready is low, so no transaction is taken and then lost.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x*x + b*x + c = 0 in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
   localparam int REQ_TDATA_W = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // coef_a, coef_b, coef_c from bit 0 up, COEF_WIDTH bits each
   input  logic [REQ_TDATA_W-1:0]           req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // root_count[1:0], root_plus[42:2], root_minus[83:43], status[84]
   output logic [qrs_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import qrs_pkg::*;

   localparam int W   = COEF_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int RB  = W + F + 1;       // square root bits
   localparam int NBW = W + F + 1;       // -b scaled
   localparam int NW  = W + F + 3;       // signed numerator
   localparam int N   = W + F + 2;       // numerator magnitude, quotient bits
   localparam int DVW = W + 1;           // |2a|
   localparam int DW  = 2 * W + 3;       // discriminant
   localparam int SQW = 1 + DVW + NBW;   // sideband through the root chain
   localparam logic signed [63:0] POS_LIM = (64'sd1 <<< (ROOT_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] NEG_MAG = 64'sd1 <<< (ROOT_WIDTH - 1);

   logic adv;

   // The chain moves whenever the output register is empty or being drained.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !reset;

   // Stage A: products.
   logic signed [W-1:0]   coef_a, coef_b, coef_c;
   logic                  va_ff;
   logic signed [W-1:0]   a_a_ff, b_a_ff;
   logic signed [2*W-1:0] bb_ff, ac_ff;

   assign coef_a = req_tdata[W-1:0];
   assign coef_b = req_tdata[2*W-1:W];
   assign coef_c = req_tdata[3*W-1:2*W];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_a_ff <= coef_a;
         b_a_ff <= coef_b;
         bb_ff  <= coef_b * coef_b;
         ac_ff  <= coef_a * coef_c;
      end
   end

   // Stage B: discriminant, root count and the operands of the later stages.
   logic signed [DW-1:0]  disc;
   logic [2*RB-1:0]       x_in;
   logic signed [NBW-1:0] nb_in;
   logic [W:0]            amag;
   logic [DVW-1:0]        den_in;
   ctl_type               ctl_b_in;
   ctl_type               ctl_b_ff;
   logic [2*RB-1:0]       x_b_ff;
   logic [SQW-1:0]        side_b_ff;

   always_comb begin
      disc   = DW'(bb_ff) - (DW'(ac_ff) <<< 2);
      x_in   = disc[DW-1] ? '0 : ((2 * RB)'(disc[2*W:0]) << (2 * F));
      nb_in  = -(NBW'(b_a_ff) <<< F);
      amag   = a_a_ff[W-1] ? -((W + 1)'(a_a_ff)) : (W + 1)'(a_a_ff);
      den_in = {amag[W-1:0], 1'b0};
      ctl_b_in.valid = va_ff;
      priority if (a_a_ff == '0) begin
         ctl_b_in.status     = STAT_NOT_QUAD;
         ctl_b_in.root_count = CNT_NONE;
      end else if (disc[DW-1]) begin
         ctl_b_in.status     = STAT_OK;
         ctl_b_in.root_count = CNT_NONE;
      end else if (disc == '0) begin
         ctl_b_in.status     = STAT_OK;
         ctl_b_in.root_count = CNT_ONE;
      end else begin
         ctl_b_in.status     = STAT_OK;
         ctl_b_in.root_count = CNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (adv) begin
         ctl_b_ff <= ctl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_b_ff    <= x_in;
         side_b_ff <= {a_a_ff[W-1], den_in, nb_in};
      end
   end

   // Square root chain: one cell per root bit.
   ctl_type          sq_ctl  [0:RB];
   logic [2*RB-1:0]  sq_x    [0:RB];
   logic [RB+1:0]    sq_rem  [0:RB];
   logic [RB-1:0]    sq_q    [0:RB];
   logic [SQW-1:0]   sq_side [0:RB];

   assign sq_ctl[0]  = ctl_b_ff;
   assign sq_x[0]    = x_b_ff;
   assign sq_rem[0]  = '0;
   assign sq_q[0]    = '0;
   assign sq_side[0] = side_b_ff;

   for (genvar k = 0; k < RB; k++) begin : g_sqrt
      qrs_sqrt_cell #(.RB(RB), .SW(SQW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .ctl_in   (sq_ctl[k]),
         .x_in     (sq_x[k]),
         .rem_in   (sq_rem[k]),
         .q_in     (sq_q[k]),
         .side_in  (sq_side[k]),
         .ctl_out  (sq_ctl[k+1]),
         .x_out    (sq_x[k+1]),
         .rem_out  (sq_rem[k+1]),
         .q_out    (sq_q[k+1]),
         .side_out (sq_side[k+1])
      );
   end

   // Stage C: numerators -b*2^F +/- s, split into sign and magnitude.
   // A zero discriminant leaves s at zero, so the single root falls out of the plus lane.
   logic signed [NBW-1:0] nb_c;
   logic [DVW-1:0]        den_c;
   logic                  aneg_c;
   logic signed [NW-1:0]  s_c, np_c, nm_c, mp_c, mm_c;
   ctl_type               ctl_c_ff;
   logic [DVW-1:0]        den_c_ff;
   logic [N-1:0]          np_c_ff, nm_c_ff;
   logic [1:0]            sign_c_ff;

   always_comb begin
      {aneg_c, den_c, nb_c} = sq_side[RB];
      s_c  = NW'($signed({1'b0, sq_q[RB]}));
      np_c = NW'(nb_c) + s_c;
      nm_c = NW'(nb_c) - s_c;
      mp_c = np_c[NW-1] ? -np_c : np_c;
      mm_c = nm_c[NW-1] ? -nm_c : nm_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c_ff <= '0;
      end else if (adv) begin
         ctl_c_ff <= sq_ctl[RB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_c_ff  <= den_c;
         np_c_ff   <= mp_c[N-1:0];
         nm_c_ff   <= mm_c[N-1:0];
         sign_c_ff <= {np_c[NW-1] ^ aneg_c, nm_c[NW-1] ^ aneg_c};
      end
   end

   // Divider chain: one cell per quotient bit, both roots side by side.
   ctl_type         dv_ctl  [0:N];
   logic [DVW-1:0]  dv_den  [0:N];
   logic [N-1:0]    dv_np   [0:N];
   logic [N-1:0]    dv_nm   [0:N];
   logic [DVW-1:0]  dv_remp [0:N];
   logic [DVW-1:0]  dv_remm [0:N];
   logic [1:0]      dv_side [0:N];

   assign dv_ctl[0]  = ctl_c_ff;
   assign dv_den[0]  = den_c_ff;
   assign dv_np[0]   = np_c_ff;
   assign dv_nm[0]   = nm_c_ff;
   assign dv_remp[0] = '0;
   assign dv_remm[0] = '0;
   assign dv_side[0] = sign_c_ff;

   for (genvar k = 0; k < N; k++) begin : g_div
      qrs_div_cell #(.N(N), .DVW(DVW), .SW(2)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .ctl_in   (dv_ctl[k]),
         .den_in   (dv_den[k]),
         .np_in    (dv_np[k]),
         .nm_in    (dv_nm[k]),
         .remp_in  (dv_remp[k]),
         .remm_in  (dv_remm[k]),
         .side_in  (dv_side[k]),
         .ctl_out  (dv_ctl[k+1]),
         .den_out  (dv_den[k+1]),
         .np_out   (dv_np[k+1]),
         .nm_out   (dv_nm[k+1]),
         .remp_out (dv_remp[k+1]),
         .remm_out (dv_remm[k+1]),
         .side_out (dv_side[k+1])
      );
   end

   // Output stage: restore the sign, clamp to the root width, clear unused roots.
   logic signed [63:0]           qp, qm, vp, vm;
   ctl_type                      ctl_o;
   logic [ROOT_WIDTH-1:0]        plus_o, minus_o;
   ctl_type                      out_ctl_ff;
   logic [ROOT_WIDTH-1:0]        plus_ff, minus_ff;

   always_comb begin
      ctl_o = dv_ctl[N];
      qp = 64'($unsigned(dv_np[N]));
      qm = 64'($unsigned(dv_nm[N]));
      if (dv_side[N][1]) begin
         vp = (qp > NEG_MAG) ? -NEG_MAG : -qp;
      end else begin
         vp = (qp > POS_LIM) ? POS_LIM : qp;
      end
      if (dv_side[N][0]) begin
         vm = (qm > NEG_MAG) ? -NEG_MAG : -qm;
      end else begin
         vm = (qm > POS_LIM) ? POS_LIM : qm;
      end
      plus_o  = (ctl_o.root_count == CNT_NONE) ? '0 : vp[ROOT_WIDTH-1:0];
      minus_o = (ctl_o.root_count == CNT_TWO) ? vm[ROOT_WIDTH-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else if (adv) begin
         out_ctl_ff <= ctl_o;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plus_ff  <= plus_o;
         minus_ff <= minus_o;
      end
   end

   assign rsp_tvalid = out_ctl_ff.valid;
   assign rsp_tdata  = {3'b000, out_ctl_ff.status, minus_ff, plus_ff, out_ctl_ff.root_count};

   a_status_no_roots : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ctl_ff.status |-> out_ctl_ff.root_count == CNT_NONE)
      else $error("non-quadratic result reports roots");

   a_count_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_ctl_ff.root_count != 2'd3)
      else $error("illegal root count");

   a_minus_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ctl_ff.root_count != CNT_TWO |-> minus_ff == '0)
      else $error("minus root set without two roots");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(plus_ff))
      else $error("stalled result changed");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quadratic root solver. Coefficient triples go in
// on the request stream and each one is solved in the bench as well. Every
// response is compared field by field against the oldest predicted solution.
// ----------------------------------------------------------------------------
module testbench;
   import qrs_pkg::*;

   localparam int CW         = COEF_WIDTH_DEF;
   localparam int FB         = FRAC_BITS_DEF;
   localparam int REQ_W      = ((3 * CW + 7) / 8) * 8;
   localparam int LATENCY    = 2 * (CW + FB) + 7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1550;

   // One solved equation as it appears on the response stream.
   typedef struct packed {
      logic                   status;
      logic [ROOT_WIDTH-1:0]  root_minus;
      logic [ROOT_WIDTH-1:0]  root_plus;
      logic [1:0]             root_count;
   } solution_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // coef_a, coef_b, coef_c from bit 0 up
   logic [REQ_W-1:0]        req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // root_count, root_plus, root_minus, status from bit 0 up
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   logic [REQ_W-1:0]  pending_coefs[$];
   solution_type      expected_solutions[$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                hold_off_cycles = 0;
   bit                stimulus_done = 1'b0;
   bit                calm_stretch = 1'b0;

   quadratic_root_solver DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Integer square root of d shifted left by 2*FB, floored.
   function automatic longint unsigned fixed_sqrt(longint unsigned d);
      logic [127:0] radicand;
      logic [127:0] trial;
      logic [63:0]  r;
      radicand = {64'd0, d} << (2 * FB);
      r = '0;
      for (int k = 56; k >= 0; k--) begin
         trial = {64'd0, r | (64'd1 << k)};
         if (trial * trial <= radicand) begin
            r = r | (64'd1 << k);
         end
      end
      return r;
   endfunction

   // Clamp to the signed root width.
   function automatic logic [ROOT_WIDTH-1:0] clamp_root(longint v);
      longint lim;
      lim = longint'(1) <<< (ROOT_WIDTH - 1);
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return v[ROOT_WIDTH-1:0];
   endfunction

   function automatic solution_type solve_equation(logic [REQ_W-1:0] coefs);
      solution_type sol;
      longint a, b, c, disc, neg_b, den, s;
      a = longint'($signed(coefs[CW-1:0]));
      b = longint'($signed(coefs[2*CW-1:CW]));
      c = longint'($signed(coefs[3*CW-1:2*CW]));
      sol = '0;
      sol.status = STAT_OK;
      sol.root_count = CNT_NONE;
      if (a == 0) begin
         sol.status = STAT_NOT_QUAD;
         return sol;
      end
      disc = b * b - 4 * a * c;
      neg_b = -b * (longint'(1) <<< FB);
      den = 2 * a;
      if (disc == 0) begin
         sol.root_count = CNT_ONE;
         sol.root_plus = clamp_root(neg_b / den);
      end else if (disc > 0) begin
         s = longint'(fixed_sqrt(disc));
         sol.root_count = CNT_TWO;
         sol.root_plus  = clamp_root((neg_b + s) / den);
         sol.root_minus = clamp_root((neg_b - s) / den);
      end
      return sol;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [REQ_W-1:0] pack_coefs(logic [CW-1:0] a, logic [CW-1:0] b,
                                                   logic [CW-1:0] c);
      logic [REQ_W-1:0] v;
      v = '0;
      v[CW-1:0] = a;
      v[2*CW-1:CW] = b;
      v[3*CW-1:2*CW] = c;
      return v;
   endfunction

   // A random coefficient: full range half the time, otherwise an extreme or a small value.
   function automatic logic [CW-1:0] random_coef();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return CW'($signed($urandom_range(0, 8)) - 4);
         default: return CW'($urandom);
      endcase
   endfunction

   // Stimulus: directed corner cases first, then random equations. Some random
   // ones are built from chosen roots so that a zero discriminant shows up often.
   initial begin
      int r1, r2, k;
      pending_coefs.push_back(pack_coefs(0, 5, 7));            // not quadratic
      pending_coefs.push_back(pack_coefs(0, 0, 0));
      pending_coefs.push_back(pack_coefs(1, 0, 1));            // no real root
      pending_coefs.push_back(pack_coefs(1, 2, 1));            // single root
      pending_coefs.push_back(pack_coefs(-1, 2, -1));
      pending_coefs.push_back(pack_coefs(1, -3, 2));           // two roots
      pending_coefs.push_back(pack_coefs(2, 0, -1));
      pending_coefs.push_back(pack_coefs(16'h8000, 16'h8000, 16'h8000));
      pending_coefs.push_back(pack_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF));
      pending_coefs.push_back(pack_coefs(16'h7FFF, 16'h8000, 16'h8000));
      pending_coefs.push_back(pack_coefs(16'h8000, 16'h7FFF, 16'h7FFF));
      pending_coefs.push_back(pack_coefs(1, 16'h8000, 16'h8000));
      pending_coefs.push_back(pack_coefs(1, 16'h7FFF, 0));
      pending_coefs.push_back(pack_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_coefs.push_back(pack_coefs(1, 0, 0));
      pending_coefs.push_back(pack_coefs(16'h8000, 0, 0));
      pending_coefs.push_back(pack_coefs(4, 4, 1));
      pending_coefs.push_back(pack_coefs(1, 0, 16'h8000));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         k = $urandom_range(0, 9);
         if (k < 2) begin
            // A double root r: x^2 - 2 r x + r^2.
            r1 = $signed($urandom_range(0, 300)) - 150;
            pending_coefs.push_back(pack_coefs(1, CW'(-2 * r1), CW'(r1 * r1)));
         end else if (k < 3) begin
            r1 = $signed($urandom_range(0, 200)) - 100;
            r2 = $signed($urandom_range(0, 200)) - 100;
            pending_coefs.push_back(pack_coefs(CW'($signed($urandom_range(1, 3))),
                                               CW'(-(r1 + r2)), CW'(r1 * r2)));
         end else begin
            pending_coefs.push_back(pack_coefs(random_coef(), random_coef(), random_coef()));
         end
      end
      stimulus_done = 1'b1;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // A calm stretch with no idling on either side.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      calm_stretch <= (cycle_count > 400 && cycle_count < 800);
   end

   // Request bookkeeping at the accepting edge: the transaction leaves the
   // queue and its solution is predicted.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_solutions.push_back(solve_equation(req_tdata));
         void'(pending_coefs.pop_front());
      end
   end

   // Driver: the head of the queue is offered until it is accepted.
   // Changes happen at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (pending_coefs.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 31)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_coefs[0];
         end else begin
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_W'({$urandom, $urandom});
         end
      end
   end

   // Receiver hold-off: once, the receiver stays stalled for a long stretch so
   // that the pipeline fills and pushes back on the request side.
   always @(negedge clock) begin
      if (cycle_count == 1500) begin
         hold_off_cycles <= 300;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && hold_off_cycles == 0 &&
                    (calm_stretch || $urandom_range(0, 99) >= 31);
   end

   // Monitor: each accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      solution_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[84:0];
         if (expected_solutions.size() == 0) begin
            report_mismatch("unexpected response", 64'(got), 64'd0);
         end else begin
            want = expected_solutions.pop_front();
            if (got.root_count !== want.root_count)
               report_mismatch("root_count", 64'(got.root_count), 64'(want.root_count));
            if (got.root_plus !== want.root_plus)
               report_mismatch("root_plus", 64'(got.root_plus), 64'(want.root_plus));
            if (got.root_minus !== want.root_minus)
               report_mismatch("root_minus", 64'(got.root_minus), 64'(want.root_minus));
            if (got.status !== want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
         end
      end
   end

   // End of run: all stimulus accepted and all responses in, then a drain.
   initial begin
      wait (stimulus_done && pending_coefs.size() == 0 && expected_solutions.size() == 0
            && !reset);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
